// ===== rtl/mate_pkg.sv =====
`default_nettype none

package mate_pkg;

   typedef logic [3:0] op_type;
   typedef logic [2:0] code_type;
   typedef logic [4:0] uop_type;

   localparam op_type OP_CLEAR  = 4'd0;
   localparam op_type OP_APPEND = 4'd1;
   localparam op_type OP_LIST   = 4'd2;
   localparam op_type OP_MAX    = 4'd3;
   localparam op_type OP_MEAN   = 4'd4;
   localparam op_type OP_INSERT = 4'd5;
   localparam op_type OP_DELETE = 4'd6;
   localparam op_type OP_SORT   = 4'd7;
   localparam op_type OP_RANGE  = 4'd8;

   localparam code_type ST_DATA     = 3'd0;
   localparam code_type ST_DONE     = 3'd1;
   localparam code_type ST_FULL     = 3'd2;
   localparam code_type ST_EMPTY    = 3'd3;
   localparam code_type ST_BADPOS   = 3'd4;
   localparam code_type ST_BADRANGE = 3'd5;

   localparam uop_type U_NOP       = 5'd0;
   localparam uop_type U_LOAD      = 5'd1;
   localparam uop_type U_CODE      = 5'd2;
   localparam uop_type U_CLEAR     = 5'd3;
   localparam uop_type U_APPEND    = 5'd4;
   localparam uop_type U_PUSH_CODE = 5'd5;
   localparam uop_type U_RD_IDX    = 5'd6;
   localparam uop_type U_CAPT      = 5'd7;
   localparam uop_type U_TEST      = 5'd8;
   localparam uop_type U_FLUSH     = 5'd9;
   localparam uop_type U_SUM       = 5'd10;
   localparam uop_type U_MAX       = 5'd11;
   localparam uop_type U_PUSH_MAX  = 5'd12;
   localparam uop_type U_INS_INIT  = 5'd13;
   localparam uop_type U_RD_PREV   = 5'd14;
   localparam uop_type U_SHIFT_UP  = 5'd15;
   localparam uop_type U_INS_FIN   = 5'd16;
   localparam uop_type U_DEL_INIT  = 5'd17;
   localparam uop_type U_RD_NEXT   = 5'd18;
   localparam uop_type U_SHIFT_DN  = 5'd19;
   localparam uop_type U_DEL_FIN   = 5'd20;
   localparam uop_type U_SRT_INIT  = 5'd21;
   localparam uop_type U_LIST_INIT = 5'd22;
   localparam uop_type U_SRT_V     = 5'd23;
   localparam uop_type U_RD_JPREV  = 5'd24;
   localparam uop_type U_SRT_MOVE  = 5'd25;
   localparam uop_type U_SRT_PUT   = 5'd26;

   typedef struct packed {
      uop_type uop;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   early;
      logic   idx_lt_cnt;
      logic   nxt_lt_cnt;
      logic   idx_gt_lim;
      logic   jdx_zero;
      logic   gt;
      logic   can_push;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/mate_req_if.sv =====
`default_nettype none

interface mate_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         req_type;
   logic signed [7:0]  position;
   logic signed [31:0] mark;
   logic signed [31:0] upper_mark;

   modport source (output valid, req_type, position, mark, upper_mark, input ready);
   modport sink (input valid, req_type, position, mark, upper_mark, output ready);
endinterface

`default_nettype wire

// ===== rtl/mate_rsp_if.sv =====
`default_nettype none

interface mate_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] value;
   logic               last;

   modport source (output valid, status, value, last, input ready);
   modport sink (input valid, status, value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/mark_array_table_engine.sv =====
// Keeps an ordered store of up to ENTRIES signed Q16.16 marks in a two-port RAM.
// Requests arrive on req_bus as valid/ready words; results leave on rsp_bus, one
// word each, with last set on the final word of a request.
// A request is taken only while the sequencer is idle. List, range and maximum
// read each stored entry in turn; the mean request reads every entry twice (a
// sum pass, then a compare pass); insert and delete move one entry at a time.
// Sort is an insertion sort over the RAM and runs before the listing starts.
// The RAM has one read and one write port with a registered read, and that port
// sets the pace of every pass above.
// Results go through a one-word output register: the next request may be taken
// while a finished word still waits. When the receiver stalls, the sequencer holds
// at the next word it has to send.
// Reset empties the store at once; the RAM contents are never cleared, since only
// entries below the count are ever read.
`default_nettype none

module mark_array_table_engine #(
   parameter int ENTRIES = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mate_req_if.sink    req_bus,
   mate_rsp_if.source  rsp_bus
);

   localparam int CW = $clog2(ENTRIES + 1);

   mate_pkg::cmd_type  cmd;
   mate_pkg::stat_type st;
   logic [CW-1:0]      count;

   mate_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .st        (st),
      .cmd       (cmd)
   );

   mate_dp #(.ENTRIES(ENTRIES), .CW(CW)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .count      (count),
      .req_type   (req_bus.req_type),
      .position   (req_bus.position),
      .mark       (req_bus.mark),
      .upper_mark (req_bus.upper_mark),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_status (rsp_bus.status),
      .rsp_value  (rsp_bus.value),
      .rsp_last   (rsp_bus.last)
   );

   count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(ENTRIES))
      else $error("Entry count exceeds the store size.");

   one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("Request taken while another is in progress.");

   value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != mate_pkg::ST_DATA)) |-> (rsp_bus.value == '0))
      else $error("Non-data word carries a value.");

endmodule

`default_nettype wire

// ===== rtl/mate_ram.sv =====
`default_nettype none

module mate_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mate_ctrl.sv =====
`default_nettype none

module mate_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire mate_pkg::stat_type st,
   output mate_pkg::cmd_type       cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DISP  = 5'd1;
   localparam logic [4:0] S_RESP  = 5'd2;
   localparam logic [4:0] S_LRD   = 5'd3;
   localparam logic [4:0] S_LCAP  = 5'd4;
   localparam logic [4:0] S_LTST  = 5'd5;
   localparam logic [4:0] S_FLUSH = 5'd6;
   localparam logic [4:0] S_MRD   = 5'd7;
   localparam logic [4:0] S_MAC   = 5'd8;
   localparam logic [4:0] S_PMAX  = 5'd9;
   localparam logic [4:0] S_SUMRD = 5'd10;
   localparam logic [4:0] S_SUMAC = 5'd11;
   localparam logic [4:0] S_IRD   = 5'd12;
   localparam logic [4:0] S_IWR   = 5'd13;
   localparam logic [4:0] S_DRD   = 5'd14;
   localparam logic [4:0] S_DWR   = 5'd15;
   localparam logic [4:0] S_SI    = 5'd16;
   localparam logic [4:0] S_SV    = 5'd17;
   localparam logic [4:0] S_SJ    = 5'd18;
   localparam logic [4:0] S_SC    = 5'd19;
   localparam logic [4:0] S_SW    = 5'd20;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.uop   = mate_pkg::U_NOP;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.uop  = mate_pkg::U_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (st.op > mate_pkg::OP_RANGE) begin
               state_in = S_IDLE;
            end else if (st.op == mate_pkg::OP_CLEAR) begin
               cmd.uop  = mate_pkg::U_CLEAR;
               state_in = S_RESP;
            end else if (st.early) begin
               cmd.uop  = mate_pkg::U_CODE;
               state_in = S_RESP;
            end else begin
               case (st.op)
                  mate_pkg::OP_APPEND: begin
                     cmd.uop  = mate_pkg::U_APPEND;
                     state_in = S_RESP;
                  end
                  mate_pkg::OP_LIST, mate_pkg::OP_RANGE: begin
                     state_in = S_LRD;
                  end
                  mate_pkg::OP_MAX: begin
                     state_in = S_MRD;
                  end
                  mate_pkg::OP_MEAN: begin
                     state_in = S_SUMRD;
                  end
                  mate_pkg::OP_INSERT: begin
                     cmd.uop  = mate_pkg::U_INS_INIT;
                     state_in = S_IRD;
                  end
                  mate_pkg::OP_DELETE: begin
                     cmd.uop  = mate_pkg::U_DEL_INIT;
                     state_in = S_DRD;
                  end
                  mate_pkg::OP_SORT: begin
                     cmd.uop  = mate_pkg::U_SRT_INIT;
                     state_in = S_SI;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RESP: begin
            if (st.can_push) begin
               cmd.uop  = mate_pkg::U_PUSH_CODE;
               state_in = S_IDLE;
            end
         end
         S_LRD: begin
            if (st.idx_lt_cnt) begin
               cmd.uop  = mate_pkg::U_RD_IDX;
               state_in = S_LCAP;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_LCAP: begin
            cmd.uop  = mate_pkg::U_CAPT;
            state_in = S_LTST;
         end
         S_LTST: begin
            if (st.can_push) begin
               cmd.uop  = mate_pkg::U_TEST;
               state_in = S_LRD;
            end
         end
         S_FLUSH: begin
            if (st.can_push) begin
               cmd.uop  = mate_pkg::U_FLUSH;
               state_in = S_IDLE;
            end
         end
         S_MRD: begin
            if (st.idx_lt_cnt) begin
               cmd.uop  = mate_pkg::U_RD_IDX;
               state_in = S_MAC;
            end else begin
               state_in = S_PMAX;
            end
         end
         S_MAC: begin
            cmd.uop  = mate_pkg::U_MAX;
            state_in = S_MRD;
         end
         S_PMAX: begin
            if (st.can_push) begin
               cmd.uop  = mate_pkg::U_PUSH_MAX;
               state_in = S_IDLE;
            end
         end
         S_SUMRD: begin
            if (st.idx_lt_cnt) begin
               cmd.uop  = mate_pkg::U_RD_IDX;
               state_in = S_SUMAC;
            end else begin
               cmd.uop  = mate_pkg::U_LIST_INIT;
               state_in = S_LRD;
            end
         end
         S_SUMAC: begin
            cmd.uop  = mate_pkg::U_SUM;
            state_in = S_SUMRD;
         end
         S_IRD: begin
            if (st.idx_gt_lim) begin
               cmd.uop  = mate_pkg::U_RD_PREV;
               state_in = S_IWR;
            end else begin
               cmd.uop  = mate_pkg::U_INS_FIN;
               state_in = S_RESP;
            end
         end
         S_IWR: begin
            cmd.uop  = mate_pkg::U_SHIFT_UP;
            state_in = S_IRD;
         end
         S_DRD: begin
            if (st.nxt_lt_cnt) begin
               cmd.uop  = mate_pkg::U_RD_NEXT;
               state_in = S_DWR;
            end else begin
               cmd.uop  = mate_pkg::U_DEL_FIN;
               state_in = S_RESP;
            end
         end
         S_DWR: begin
            cmd.uop  = mate_pkg::U_SHIFT_DN;
            state_in = S_DRD;
         end
         S_SI: begin
            if (st.idx_lt_cnt) begin
               cmd.uop  = mate_pkg::U_RD_IDX;
               state_in = S_SV;
            end else begin
               cmd.uop  = mate_pkg::U_LIST_INIT;
               state_in = S_LRD;
            end
         end
         S_SV: begin
            cmd.uop  = mate_pkg::U_SRT_V;
            state_in = S_SJ;
         end
         S_SJ: begin
            if (st.jdx_zero) begin
               state_in = S_SW;
            end else begin
               cmd.uop  = mate_pkg::U_RD_JPREV;
               state_in = S_SC;
            end
         end
         S_SC: begin
            if (st.gt) begin
               cmd.uop  = mate_pkg::U_SRT_MOVE;
               state_in = S_SJ;
            end else begin
               state_in = S_SW;
            end
         end
         S_SW: begin
            cmd.uop  = mate_pkg::U_SRT_PUT;
            state_in = S_SI;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mate_dp.sv =====
`default_nettype none

module mate_dp #(
   parameter int ENTRIES = 64,
   parameter int CW      = $clog2(ENTRIES + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mate_pkg::cmd_type  cmd,
   output mate_pkg::stat_type      st,
   output logic [CW-1:0]           count,
   input  wire logic [3:0]         req_type,
   input  wire logic signed [7:0]  position,
   input  wire logic signed [31:0] mark,
   input  wire logic signed [31:0] upper_mark,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_value,
   output logic                    rsp_last
);

   localparam int AW  = $clog2(ENTRIES);
   localparam int PRW = 33 + CW;

   logic [3:0]               op_ff, op_in;
   logic signed [7:0]        pos_ff, pos_in;
   logic signed [31:0]       mark_ff, mark_in;
   logic signed [31:0]       upper_ff, upper_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            jdx_ff, jdx_in;
   logic [CW-1:0]            lim_ff, lim_in;
   logic signed [PRW-1:0]    sum_ff, sum_in;
   logic signed [PRW-1:0]    prod_ff, prod_in;
   logic signed [31:0]       data_ff, data_in;
   logic signed [31:0]       acc_ff, acc_in;
   logic                     pend_v_ff, pend_v_in;
   logic signed [31:0]       pend_ff, pend_in;
   logic [2:0]               code_ff, code_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               rsp_status_ff, rsp_status_in;
   logic signed [31:0]       rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [31:0]              wr_data;
   logic [AW-1:0]            rd_addr;
   logic [31:0]              rd_data;
   logic signed [31:0]       rd_sig;
   logic signed [PRW-1:0]    mul_w;
   logic                     full, empty, badpos, badrange, hit, can_push;
   logic                     early_hit;
   logic [2:0]               early_code;
   logic [CW-1:0]            ins_p, del_p;
   int                       pos_i, cnt_i;

   mate_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_sig   = $signed(rd_data);
   assign mul_w    = rd_sig * $signed({1'b0, count_ff});
   assign pos_i    = int'(pos_ff);
   assign cnt_i    = int'(count_ff);
   assign full     = (count_ff == CW'(ENTRIES));
   assign empty    = (count_ff == '0);
   assign badpos   = (pos_i < 0) || (pos_i > ENTRIES);
   assign badrange = (mark_ff > upper_ff);
   assign can_push = !rsp_valid_ff || rsp_ready;

   always_comb begin
      early_code = mate_pkg::ST_DONE;
      early_hit  = 1'b0;
      if (op_ff == mate_pkg::OP_APPEND) begin
         early_hit  = full;
         early_code = mate_pkg::ST_FULL;
      end else if (empty) begin
         early_hit  = 1'b1;
         early_code = mate_pkg::ST_EMPTY;
      end else if ((op_ff == mate_pkg::OP_INSERT) && full) begin
         early_hit  = 1'b1;
         early_code = mate_pkg::ST_FULL;
      end else if ((op_ff == mate_pkg::OP_DELETE) && badpos) begin
         early_hit  = 1'b1;
         early_code = mate_pkg::ST_BADPOS;
      end else if ((op_ff == mate_pkg::OP_RANGE) && badrange) begin
         early_hit  = 1'b1;
         early_code = mate_pkg::ST_BADRANGE;
      end
   end

   always_comb begin
      if (pos_i < 0) begin
         ins_p = '0;
      end else if (pos_i > cnt_i) begin
         ins_p = count_ff;
      end else begin
         ins_p = pos_ff[CW-1:0];
      end
      if (pos_i >= cnt_i) begin
         del_p = count_ff - CW'(1);
      end else begin
         del_p = pos_ff[CW-1:0];
      end
   end

   always_comb begin
      case (op_ff)
         mate_pkg::OP_MEAN:  hit = (prod_ff >= sum_ff);
         mate_pkg::OP_RANGE: hit = (data_ff >= mark_ff) && (data_ff <= upper_ff);
         default:            hit = 1'b1;
      endcase
   end

   assign st.op         = op_ff;
   assign st.early      = early_hit;
   assign st.idx_lt_cnt = (idx_ff < count_ff);
   assign st.nxt_lt_cnt = ((idx_ff + CW'(1)) < count_ff);
   assign st.idx_gt_lim = (idx_ff > lim_ff);
   assign st.jdx_zero   = (jdx_ff == '0);
   assign st.gt         = (rd_sig > acc_ff);
   assign st.can_push   = can_push;

   always_comb begin
      op_in         = op_ff;
      pos_in        = pos_ff;
      mark_in       = mark_ff;
      upper_in      = upper_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      jdx_in        = jdx_ff;
      lim_in        = lim_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      data_in       = data_ff;
      acc_in        = acc_ff;
      pend_v_in     = pend_v_ff;
      pend_in       = pend_ff;
      code_in       = code_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = rd_data;
      rd_addr       = idx_ff[AW-1:0];
      case (cmd.uop)
         mate_pkg::U_LOAD: begin
            op_in     = req_type;
            pos_in    = position;
            mark_in   = mark;
            upper_in  = upper_mark;
            idx_in    = '0;
            pend_v_in = 1'b0;
            sum_in    = '0;
         end
         mate_pkg::U_CODE: begin
            code_in = early_code;
         end
         mate_pkg::U_CLEAR: begin
            count_in = '0;
            code_in  = mate_pkg::ST_DONE;
         end
         mate_pkg::U_APPEND: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[AW-1:0];
            wr_data  = mark_ff;
            count_in = count_ff + CW'(1);
            code_in  = mate_pkg::ST_DONE;
         end
         mate_pkg::U_PUSH_CODE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = code_ff;
            rsp_value_in  = '0;
            rsp_last_in   = 1'b1;
         end
         mate_pkg::U_RD_IDX: begin
            rd_addr = idx_ff[AW-1:0];
         end
         mate_pkg::U_CAPT: begin
            data_in = rd_sig;
            prod_in = mul_w;
         end
         mate_pkg::U_TEST: begin
            idx_in = idx_ff + CW'(1);
            if (hit) begin
               if (pend_v_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mate_pkg::ST_DATA;
                  rsp_value_in  = pend_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_in   = data_ff;
               pend_v_in = 1'b1;
            end
         end
         mate_pkg::U_FLUSH: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            if (pend_v_ff) begin
               rsp_status_in = mate_pkg::ST_DATA;
               rsp_value_in  = pend_ff;
            end else begin
               rsp_status_in = mate_pkg::ST_DONE;
               rsp_value_in  = '0;
            end
         end
         mate_pkg::U_SUM: begin
            sum_in = sum_ff + PRW'(rd_sig);
            idx_in = idx_ff + CW'(1);
         end
         mate_pkg::U_MAX: begin
            if ((idx_ff == '0) || (rd_sig > acc_ff)) begin
               acc_in = rd_sig;
            end
            idx_in = idx_ff + CW'(1);
         end
         mate_pkg::U_PUSH_MAX: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = mate_pkg::ST_DATA;
            rsp_value_in  = acc_ff;
            rsp_last_in   = 1'b1;
         end
         mate_pkg::U_INS_INIT: begin
            idx_in = count_ff;
            lim_in = ins_p;
         end
         mate_pkg::U_RD_PREV: begin
            rd_addr = AW'(idx_ff - CW'(1));
         end
         mate_pkg::U_SHIFT_UP: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            idx_in  = idx_ff - CW'(1);
         end
         mate_pkg::U_INS_FIN: begin
            wr_en    = 1'b1;
            wr_addr  = lim_ff[AW-1:0];
            wr_data  = mark_ff;
            count_in = count_ff + CW'(1);
            code_in  = mate_pkg::ST_DONE;
         end
         mate_pkg::U_DEL_INIT: begin
            idx_in = del_p;
         end
         mate_pkg::U_RD_NEXT: begin
            rd_addr = AW'(idx_ff + CW'(1));
         end
         mate_pkg::U_SHIFT_DN: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            idx_in  = idx_ff + CW'(1);
         end
         mate_pkg::U_DEL_FIN: begin
            count_in = count_ff - CW'(1);
            code_in  = mate_pkg::ST_DONE;
         end
         mate_pkg::U_SRT_INIT: begin
            idx_in = CW'(1);
         end
         mate_pkg::U_LIST_INIT: begin
            idx_in    = '0;
            pend_v_in = 1'b0;
         end
         mate_pkg::U_SRT_V: begin
            acc_in = rd_sig;
            jdx_in = idx_ff;
         end
         mate_pkg::U_RD_JPREV: begin
            rd_addr = AW'(jdx_ff - CW'(1));
         end
         mate_pkg::U_SRT_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = jdx_ff[AW-1:0];
            wr_data = rd_data;
            jdx_in  = jdx_ff - CW'(1);
         end
         mate_pkg::U_SRT_PUT: begin
            wr_en   = 1'b1;
            wr_addr = jdx_ff[AW-1:0];
            wr_data = acc_ff;
            idx_in  = idx_ff + CW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      mark_ff       <= mark_in;
      upper_ff      <= upper_in;
      idx_ff        <= idx_in;
      jdx_ff        <= jdx_in;
      lim_ff        <= lim_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      data_ff       <= data_in;
      acc_ff        <= acc_in;
      pend_ff       <= pend_in;
      code_ff       <= code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign count      = count_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire
